/* rtl/core/qcr_pkg.sv */
// Shared types and constants for the quadrature counter with reference reload.
// Used by the front, queue, back and top-level modules; depends on nothing.
package qcr_pkg;

    // Step classification reported with every result.
    typedef enum logic [1:0] {
        STEP_NONE    = 2'd0,
        STEP_INC     = 2'd1,
        STEP_DEC     = 2'd2,
        STEP_ILLEGAL = 2'd3
    } t_step_status;

    // Request kinds carried on the input tuser.
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_PRELOAD = 1'b1;

    // Register indexes, taken from address bit 2.
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_REF   = 1'b1;

    // Queue geometry between the front and the back.
    localparam int QDepth = 2;
    localparam int QAw    = $clog2(QDepth);

    // Deviation limit on |old count - reference| * scale.
    localparam logic [32:0] DEV_LIMIT = 33'd100000;

    // Length = floor(p / 10000) with p = count * scale. A product at or above
    // 65536 * 10000 saturates; below that, p / 16 is divided by 625 through a
    // reciprocal multiply that lands on the quotient or one below it.
    localparam logic [46:0] LEN_SAT_LIMIT = 47'd655360000;
    localparam logic [24:0] LEN_RECIP     = 25'd27487790;  // floor(2^34 / 625)
    localparam int          LenShift      = 34;
    localparam logic [9:0]  LEN_DIV_LO    = 10'd625;
    localparam logic [15:0] LEN_MAX       = 16'hFFFF;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic [31:0]  pos;      // count after this item
        logic [31:0]  pre;      // count before a reference reload
        t_step_status status;
        logic         dir_up;
        logic         hit;
        logic         first;
    } t_qcr_item;

    // One finished result.
    typedef struct packed {
        logic [31:0]  pos;
        logic [15:0]  length;
        t_step_status status;
        logic         dir_up;
        logic         hit;
        logic         first;
        logic         dev;
    } t_qcr_result;

endpackage

/* rtl/core/qcr_front.sv */
// Front part: decodes each accepted request and updates the counter state.
// Depends on qcr_pkg for the item type and step codes.
module qcr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_req_type,
    input  logic [2:0]         i_levels,
    input  logic [31:0]        i_preload,
    input  logic [31:0]        i_ref_value,
    output logic               o_push,
    output qcr_pkg::t_qcr_item o_item
);
    import qcr_pkg::*;

    logic [2:0]   r_levels, n_levels;
    logic         r_primed, n_primed;
    logic [31:0]  r_count, n_count;
    logic         r_dir_up, n_dir_up;
    logic         r_awaiting, n_awaiting;

    logic [2:0]   w_changed;
    logic         w_differ;
    logic         w_up;
    logic [31:0]  w_stepped;
    t_step_status w_status;
    t_qcr_item    w_item;

    // Edge detection against the previous sample.
    assign w_changed = i_levels ^ r_levels;
    assign w_differ  = i_levels[0] ^ i_levels[1];

    // x4 quadrature decode of the A/B change.
    always_comb begin
        w_up     = 1'b0;
        w_status = STEP_NONE;
        unique case (w_changed[1:0])
            2'b01: begin
                w_up     = ~w_differ;
                w_status = w_up ? STEP_INC : STEP_DEC;
            end
            2'b10: begin
                w_up     = w_differ;
                w_status = w_up ? STEP_INC : STEP_DEC;
            end
            2'b11: begin
                w_status = STEP_ILLEGAL;
            end
            default: begin
                w_status = STEP_NONE;
            end
        endcase
    end

    // Next state and the item handed to the queue.
    always_comb begin
        n_levels   = r_levels;
        n_primed   = r_primed;
        n_count    = r_count;
        n_dir_up   = r_dir_up;
        n_awaiting = r_awaiting;
        w_stepped  = r_count;
        w_item     = '0;
        if (i_req_type == REQ_PRELOAD) begin
            n_count    = i_preload;
            w_item.pos = i_preload;
            w_item.pre = i_preload;
        end else if (!r_primed) begin
            n_primed   = 1'b1;
            n_levels   = i_levels;
            w_item.pos = r_count;
            w_item.pre = r_count;
        end else begin
            n_levels = i_levels;
            if (w_status == STEP_INC || w_status == STEP_DEC) begin
                w_stepped = w_up ? r_count + 32'd1 : r_count - 32'd1;
                n_dir_up  = w_up;
            end
            n_count       = w_stepped;
            w_item.status = w_status;
            w_item.pre    = w_stepped;
            w_item.pos    = w_stepped;
            // Falling reference edge while moving up reloads the counter.
            if (w_changed[2] && n_dir_up && !i_levels[2]) begin
                n_count      = i_ref_value;
                w_item.pos   = i_ref_value;
                w_item.hit   = 1'b1;
                w_item.first = r_awaiting;
                n_awaiting   = 1'b0;
            end
        end
        w_item.dir_up = n_dir_up;
    end

    // Counter state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels   <= '0;
            r_primed   <= 1'b0;
            r_count    <= '0;
            r_dir_up   <= 1'b0;
            r_awaiting <= 1'b1;
        end else if (i_valid) begin
            r_levels   <= n_levels;
            r_primed   <= n_primed;
            r_count    <= n_count;
            r_dir_up   <= n_dir_up;
            r_awaiting <= n_awaiting;
        end
    end

    assign o_push = i_valid;
    assign o_item = w_item;

endmodule

/* rtl/core/qcr_queue.sv */
// Short queue that decouples the front from the back.
// Depends on qcr_pkg for the item type and queue depth.
module qcr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  qcr_pkg::t_qcr_item i_item,
    input  logic               i_pop,
    output qcr_pkg::t_qcr_item o_item,
    output logic               o_valid,
    output logic               o_full
);
    import qcr_pkg::*;

    t_qcr_item        r_mem [QDepth];
    logic [QAw-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAw-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QAw:0]     r_fill, n_fill;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_valid = (r_fill != '0);
    assign o_full  = (r_fill == (QAw+1)'(QDepth));

endmodule

/* rtl/core/qcr_back.sv */
// Back part: three-stage pipeline computing length and deviation per item.
// Depends on qcr_pkg for the item and result types and the fixed constants.
module qcr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qcr_pkg::t_qcr_item   i_item,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  logic [15:0]          i_scale,
    input  logic [31:0]          i_ref_value,
    input  logic                 i_ready,
    output logic                 o_valid,
    output qcr_pkg::t_qcr_result o_result
);
    import qcr_pkg::*;

    logic         w_en;
    logic         r_v1, r_v2, r_v3;

    // Stage 1 registers.
    t_qcr_item    r1_item;
    logic [32:0]  r1_mag;
    logic [46:0]  r1_prod;
    // Stage 2 registers.
    t_qcr_item    r2_item;
    logic         r2_dev;
    logic         r2_sat;
    logic [25:0]  r2_x;
    logic [16:0]  r2_q0;
    // Stage 3 (output) register.
    t_qcr_result  r3_res;

    logic [32:0]  w_diff_a, w_diff_b, w_mag;
    logic [30:0]  w_pos_nn;
    logic [46:0]  w_prod;
    logic [32:0]  w_dev_prod;
    logic         w_dev;
    logic [25:0]  w_x;
    logic [50:0]  w_qm;
    logic [26:0]  w_qp, w_rem;
    logic [16:0]  w_q;

    // The whole pipeline advances whenever the output slot is free or taken.
    assign w_en  = ~r_v3 | i_ready;
    assign o_pop = w_en & i_valid;

    // Stage 1: exact 33-bit deviation magnitude and the length product.
    assign w_diff_a = {i_ref_value[31], i_ref_value} - {i_item.pre[31], i_item.pre};
    assign w_diff_b = {i_item.pre[31], i_item.pre} - {i_ref_value[31], i_ref_value};
    assign w_mag    = w_diff_a[32] ? w_diff_b : w_diff_a;
    assign w_pos_nn = i_item.pos[31] ? 31'd0 : i_item.pos[30:0];
    assign w_prod   = {16'd0, w_pos_nn} * {31'd0, i_scale};

    // Stage 2: deviation compare and the reciprocal multiply for length.
    // A magnitude above the limit fails for any nonzero scale, so the
    // multiply only needs the low 17 bits.
    assign w_dev_prod = {16'd0, r1_mag[16:0]} * {17'd0, i_scale};
    assign w_dev      = r1_item.hit && (i_scale != 16'd0)
                        && ((r1_mag > DEV_LIMIT) || (w_dev_prod > DEV_LIMIT));
    assign w_x        = r1_prod[29:4];
    assign w_qm       = {25'd0, w_x} * {26'd0, LEN_RECIP};

    // Stage 3: one correction step on the quotient, then saturation.
    assign w_qp  = 27'(r2_q0) * 27'(LEN_DIV_LO);
    assign w_rem = {1'b0, r2_x} - w_qp;
    assign w_q   = (w_rem >= 27'(LEN_DIV_LO)) ? r2_q0 + 17'd1 : r2_q0;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_item <= i_item;
            r1_mag  <= w_mag;
            r1_prod <= w_prod;

            r2_item <= r1_item;
            r2_dev  <= w_dev;
            r2_sat  <= (r1_prod >= LEN_SAT_LIMIT);
            r2_x    <= w_x;
            r2_q0   <= w_qm[LenShift+16:LenShift];

            r3_res.pos    <= r2_item.pos;
            r3_res.length <= r2_sat ? LEN_MAX : w_q[15:0];
            r3_res.status <= r2_item.status;
            r3_res.dir_up <= r2_item.dir_up;
            r3_res.hit    <= r2_item.hit;
            r3_res.first  <= r2_item.first;
            r3_res.dev    <= r2_dev;
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r3_res;

endmodule

/* rtl/core/quadrature_counter_with_reference_core.sv */
// Top level of the quadrature counter with reference reload.
// Instantiates qcr_front, qcr_queue and qcr_back; depends on qcr_pkg.
//
// The block takes one request per clock: a pin sample (A, B and reference
// levels) or a counter preload, and returns exactly one result per request.
// The sustained rate is one item per cycle while the output is not stalled,
// set by the counter update in the front; length and deviation are finished
// in a three-stage back pipeline behind a two-entry queue. A stalled output
// freezes the whole back pipeline, and input is blocked once the two-entry
// queue in front of it is full. No clearing pass is needed after reset.
// Configuration writes are expected only while no results are pending.
module quadrature_counter_with_reference_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // chan_a, chan_b, ref_sensor, preload_value[31:0]
    input  logic        i_s_axis_tuser,  // req_type
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // position[31:0], length_units[15:0], step_status[1:0], moving_up,
    // reference_hit, first_reference, deviation_error, zero pad[1:0]
    output logic [55:0] o_m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qcr_pkg::*;

    logic [15:0] r_scale;
    logic [31:0] r_ref;
    logic        w_cfg_wr;
    logic        w_accept;
    logic        w_push;
    t_qcr_item   w_front_item;
    t_qcr_item   w_q_item;
    logic        w_q_valid, w_q_full, w_pop;
    logic        w_res_valid;
    t_qcr_result w_res;

    // Configuration registers.
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 16'd100;
            r_ref   <= 32'd100;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_SCALE) begin
                r_scale <= pwdata[15:0];
            end else begin
                r_ref <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_REF) ? r_ref : {16'd0, r_scale};

    // Input handshake.
    assign o_s_axis_tready = ~w_q_full;
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    qcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_req_type  (i_s_axis_tuser),
        .i_levels    (i_s_axis_tdata[2:0]),
        .i_preload   (i_s_axis_tdata[34:3]),
        .i_ref_value (r_ref),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    qcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    qcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_q_item),
        .i_valid     (w_q_valid),
        .o_pop       (w_pop),
        .i_scale     (r_scale),
        .i_ref_value (r_ref),
        .i_ready     (i_m_axis_tready),
        .o_valid     (w_res_valid),
        .o_result    (w_res)
    );

    // Result packing.
    assign o_m_axis_tvalid = w_res_valid;
    assign o_m_axis_tdata  = {2'b00, w_res.dev, w_res.first, w_res.hit, w_res.dir_up,
                              w_res.status, w_res.length, w_res.pos};

endmodule

/* rtl/core/qcr_checker.sv */
// Port-level checks for the quadrature counter with reference reload.
// Bound to quadrature_counter_with_reference_core; uses qcr_pkg for the step codes.
module qcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata
);
    import qcr_pkg::*;

    logic r_first_seen;
    logic w_out_accept;

    assign w_out_accept = o_m_axis_tvalid & i_m_axis_tready;

    // Remembers that a first-reference result has been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_seen <= 1'b0;
        end else if (w_out_accept && o_m_axis_tdata[52]) begin
            r_first_seen <= 1'b1;
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // A counted step agrees with the reported direction.
    a_dir_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[49:48] == STEP_INC
                             || o_m_axis_tdata[49:48] == STEP_DEC))
            |-> (o_m_axis_tdata[50] == (o_m_axis_tdata[49:48] == STEP_INC)))
        else $error("step direction and moving_up disagree");

    // First-reference and deviation flags only come with a reload.
    a_flags_need_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[52] || o_m_axis_tdata[53]))
            |-> o_m_axis_tdata[51])
        else $error("reference flag without a reload");

    // A negative position has zero length.
    a_neg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[31]) |-> (o_m_axis_tdata[47:32] == 16'd0))
        else $error("nonzero length for negative position");

    // The first-reference flag is delivered at most once after reset.
    a_first_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_accept && o_m_axis_tdata[52]) |-> !r_first_seen)
        else $error("first reference reported twice");

endmodule

bind quadrature_counter_with_reference_core qcr_checker u_qcr_checker (.*);

/* tb/qcr_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the quadrature counter with reference reload.
// Watches the request, result and register channels, predicts every result
// and compares it field by field. Depends on qcr_pkg.
module qcr_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel as seen at the block's input.
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [39:0] i_req_data,   // chan_a, chan_b, ref_sensor, preload_value[31:0]
    input  logic        i_req_user,   // req_type
    // Result channel as seen at the block's output.
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    // position[31:0], length_units[15:0], step_status[1:0], moving_up,
    // reference_hit, first_reference, deviation_error
    input  logic [55:0] i_res_data,
    // Register port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);
    import qcr_pkg::*;

    localparam logic [63:0] LENGTH_DIVISOR  = 64'd10000;
    localparam longint      DEVIATION_LIMIT = 100000;
    localparam int          REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [31:0]  pos;
        logic [15:0]  len;
        t_step_status step;
        logic         up;
        logic         hit;
        logic         first;
        logic         dev;
    } t_reading;

    // Results predicted but not yet seen, oldest first.
    t_reading    expected_readings[$];

    // Predicted state of the counter and its registers.
    logic [15:0] scale_q;
    logic [31:0] ref_q;
    logic [2:0]  last_levels;
    logic        primed_q;
    logic [31:0] count_q;
    logic        up_q;
    logic        first_pending_q;

    // Length in units: truncated quotient saturating at 65535, negative counts give zero.
    function automatic logic [15:0] length_of_count(input logic [31:0] cnt,
                                                    input logic [15:0] scale);
        logic [63:0] quot;
        if (cnt[31]) begin
            return 16'd0;
        end
        quot = ({32'd0, cnt} * {48'd0, scale}) / LENGTH_DIVISOR;
        return (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
    endfunction

    // Advance the predicted counter by one request and queue its result.
    task automatic predict_reading(input logic kind, input logic [39:0] d);
        t_reading   r;
        logic [2:0] lv;
        logic [2:0] moved;
        logic       step_up;
        longint     gap;
        r       = '0;
        r.step  = STEP_NONE;
        step_up = 1'b0;
        if (kind == REQ_PRELOAD) begin
            count_q = d[34:3];
        end else begin
            lv = d[2:0];
            if (!primed_q) begin
                primed_q = 1'b1;
            end else begin
                moved = lv ^ last_levels;
                case (moved[1:0])
                    2'b01: begin
                        step_up = (lv[0] == lv[1]);
                        r.step  = step_up ? STEP_INC : STEP_DEC;
                    end
                    2'b10: begin
                        step_up = (lv[0] != lv[1]);
                        r.step  = step_up ? STEP_INC : STEP_DEC;
                    end
                    2'b11: begin
                        r.step = STEP_ILLEGAL;
                    end
                    default: begin
                    end
                endcase
                if (r.step == STEP_INC || r.step == STEP_DEC) begin
                    count_q = step_up ? count_q + 32'd1 : count_q - 32'd1;
                    up_q    = step_up;
                end
                // A falling reference edge while moving up reloads the count.
                if (moved[2] && up_q && !lv[2]) begin
                    gap = longint'($signed(ref_q)) - longint'($signed(count_q));
                    if (gap < 0) begin
                        gap = -gap;
                    end
                    r.hit           = 1'b1;
                    r.first         = first_pending_q;
                    first_pending_q = 1'b0;
                    r.dev           = (gap * longint'(scale_q)) > DEVIATION_LIMIT;
                    count_q         = ref_q;
                end
            end
            last_levels = lv;
        end
        r.pos = count_q;
        r.len = length_of_count(count_q, scale_q);
        r.up  = up_q;
        expected_readings.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
            end
        end
    endtask

    // Compare results first: a result never belongs to a request taken at the same edge.
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            scale_q         = 16'd100;
            ref_q           = 32'd100;
            last_levels     = 3'b000;
            primed_q        = 1'b0;
            count_q         = 32'd0;
            up_q            = 1'b0;
            first_pending_q = 1'b1;
            expected_readings.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_readings.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result %0h", $time, i_res_data);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    check_field("position", want.pos, i_res_data[31:0]);
                    check_field("length_units", 32'(want.len), 32'(i_res_data[47:32]));
                    check_field("step_status", 32'(want.step), 32'(i_res_data[49:48]));
                    check_field("moving_up", 32'(want.up), 32'(i_res_data[50]));
                    check_field("reference_hit", 32'(want.hit), 32'(i_res_data[51]));
                    check_field("first_reference", 32'(want.first), 32'(i_res_data[52]));
                    check_field("deviation_error", 32'(want.dev), 32'(i_res_data[53]));
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_reading(i_req_user, i_req_data);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_SCALE) begin
                    scale_q = i_pwdata[15:0];
                end else begin
                    ref_q = i_pwdata;
                end
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

/* tb/quadrature_counter_with_reference_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the quadrature counter with reference reload.
// Drives requests, result back-pressure and register writes, and takes the
// verdict from qcr_result_checker. Depends on qcr_pkg and the core.
module quadrature_counter_with_reference_core_tb;
    import qcr_pkg::*;

    localparam int          LATENCY     = 3;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PHASE_ITEMS = 125;
    localparam logic [2:0]  ADDR_SCALE  = {REG_SCALE, 2'b00};
    localparam logic [2:0]  ADDR_REF    = {REG_REF, 2'b00};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // chan_a, chan_b, ref_sensor, preload_value[31:0]
    logic        s_tuser  = REQ_SAMPLE;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // position, length_units, step_status, flags
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_count;
    int          cycle_count   = 0;

    // Traffic shaping and the walk of the simulated encoder.
    logic        src_idle_on   = 1'b1;
    logic        sink_idle_on  = 1'b1;
    logic        hold_req      = 1'b0;
    int          hold_left     = 0;
    logic        walk_up       = 1'b1;
    logic        lv_a          = 1'b0;
    logic        lv_b          = 1'b0;
    logic        lv_r          = 1'b0;
    logic [31:0] ref_now       = 32'd100;

    always #6 clk = ~clk;

    quadrature_counter_with_reference_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    qcr_result_checker u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_req_user   (s_tuser),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Result side: random back-pressure, a long hold-off when requested, or always ready.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= 80;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (sink_idle_on) begin
            m_tready <= ($urandom_range(0, 99) >= 25);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one request and return at the edge that accepts it.
    task automatic send_request(input logic kind, input logic [39:0] payload);
        while (src_idle_on && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= kind;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    // Pin sample; the unused preload bits carry noise.
    task automatic send_sample(input logic a, input logic b, input logic r);
        logic [31:0] noise;
        noise = $urandom;
        send_request(REQ_SAMPLE, {5'd0, noise, r, b, a});
    endtask

    // Counter preload; the unused pin bits carry noise.
    task automatic send_preload(input logic [31:0] value);
        logic [2:0] noise;
        noise = 3'($urandom_range(0, 7));
        send_request(REQ_PRELOAD, {5'd0, value, noise});
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drain all results, then load both registers.
    task automatic configure_block(input logic [15:0] scale, input logic [31:0] refv);
        logic [31:0] word;
        word       = $urandom;
        word[15:0] = scale;
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (LATENCY + 2) @(posedge clk);
        write_register(ADDR_SCALE, word);
        write_register(ADDR_REF, refv);
        ref_now = refv;
    endtask

    // Mostly legal encoder walks with reference toggles, plus preloads and noise.
    task automatic run_random_items(input int count, input int hold_at);
        int          pick;
        logic [1:0]  idx;
        logic [31:0] value;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_req = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    value = $urandom;
                end else if (pick < 70) begin
                    value = ref_now + $urandom_range(0, 4000) - 32'd2000;
                end else begin
                    value = $urandom_range(0, 32'h00FF_FFFF);
                end
                send_preload(value);
            end else begin
                if ($urandom_range(0, 99) < 10) begin
                    walk_up = ~walk_up;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // Step along the Gray sequence of (A, B).
                    idx  = {lv_a, lv_a ^ lv_b};
                    idx  = walk_up ? idx + 2'd1 : idx - 2'd1;
                    lv_a = idx[1];
                    lv_b = idx[1] ^ idx[0];
                end else if (pick < 80) begin
                    lv_a = ~lv_a;
                    lv_b = ~lv_b;
                end
                if ($urandom_range(0, 99) < 15) begin
                    lv_r = ~lv_r;
                end
                send_sample(lv_a, lv_b, lv_r);
            end
        end
    endtask

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values.
        send_preload(32'h7FFF_FFFF);   // preload before priming, length saturates
        send_sample(1'b0, 1'b0, 1'b1); // priming sample
        send_sample(1'b0, 1'b1, 1'b1); // count up wraps to the most negative value
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0); // first reference hit with a large deviation
        send_sample(1'b0, 1'b0, 1'b0); // illegal step
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1); // count down
        send_sample(1'b1, 1'b0, 1'b0); // falling reference while moving down
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0); // step up and reference hit together
        send_preload(32'hFFFF_FFFF);
        send_preload(32'h8000_0000);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0); // illegal step with a reference hit
        send_preload(32'd6553599);     // largest unsaturated length
        send_preload(32'd6553600);     // first saturated length
        send_sample(1'b1, 1'b1, 1'b1);
        send_preload(32'd1099);
        send_sample(1'b1, 1'b0, 1'b0); // deviation exactly at the limit
        send_sample(1'b1, 1'b0, 1'b1);
        send_preload(32'd1100);
        send_sample(1'b0, 1'b0, 1'b0); // deviation just over the limit
        send_preload(32'd0);
        send_sample(1'b0, 1'b0, 1'b0); // no change
        lv_a = 1'b0;
        lv_b = 1'b0;
        lv_r = 1'b0;

        // Random phases over several register settings.
        configure_block(16'hFFFF, 32'h8000_0000);
        run_random_items(PHASE_ITEMS, -1);

        configure_block(16'd0, 32'h7FFF_FFFF);
        run_random_items(PHASE_ITEMS, -1);

        // No idling on either side.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        configure_block(16'd1, 32'd0);
        run_random_items(PHASE_ITEMS, -1);

        // Result side holds off while requests keep coming.
        sink_idle_on = 1'b1;
        configure_block(16'd10000, 32'hFFFF_FFFB);
        run_random_items(PHASE_ITEMS, 20);

        src_idle_on = 1'b1;
        configure_block(16'($urandom_range(0, 65535)), $urandom);
        run_random_items(PHASE_ITEMS, -1);

        configure_block(16'($urandom_range(50, 200)), $urandom_range(0, 2000) - 1000);
        run_random_items(PHASE_ITEMS, -1);

        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (LATENCY + 2) @(posedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/qcr_pkg.sv
rtl/core/qcr_front.sv
rtl/core/qcr_queue.sv
rtl/core/qcr_back.sv
rtl/core/quadrature_counter_with_reference_core.sv
rtl/core/qcr_checker.sv
tb/qcr_result_checker.sv
tb/quadrature_counter_with_reference_core_tb.sv
